/* hdl/llca_pkg.sv */
// Package for the line-line closest approach pipeline.
// Holds the fixed widths, the parameter clamp and the geometry word type.
// No dependencies.
`default_nettype none

package llca_pkg;

    // Coordinate and derived widths.
    localparam int CW     = 24;          // input and output coordinate
    localparam int DFW    = CW + 1;      // wire and offset vectors
    localparam int PRW    = 2 * DFW;     // one 25x25 product
    localparam int DOTW   = PRW + 2;     // sum of three products
    localparam int MAGW   = PRW;         // magnitude of a dot product
    localparam int HW     = MAGW / 2;    // half of a split operand
    localparam int UPW    = 2 * MAGW;    // magnitude of a dot-product product
    localparam int NW     = UPW + 2;     // signed determinant and numerators
    localparam int FRAC   = 16;          // fraction bits of s and t
    localparam int QW     = 47;          // parameter magnitude bits
    localparam int XW     = UPW + QW + 3;// divider remainder
    localparam int DSTG   = QW + 1;      // divider stages (overflow + QW bits)
    localparam int QLW    = 24;          // low split of the parameter
    localparam int QHW    = QW - QLW;    // high split of the parameter
    localparam int SPW    = QW + CW + 1; // parameter times component
    localparam int RW     = SPW - FRAC;  // rounded scaled component
    localparam int PTW    = RW + 4;      // closest point before clipping
    localparam int GW     = PTW + 1;     // gap before clipping

    localparam logic [QW-1:0] PAR_LIMIT = {QW{1'b1}};

    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    // Geometry that travels down the pipeline with each word.
    typedef struct packed {
        logic [2:0][CW-1:0]  pos;
        logic [2:0][CW-1:0]  bot;
        logic [2:0][CW-1:0]  dir;
        logic [2:0][DFW-1:0] wv;
    } geo_t;

    // Per-word control bits carried through the divider.
    typedef struct packed {
        logic par;
        logic neg_s;
        logic neg_t;
        logic ovf_s;
        logic ovf_t;
    } dctl_t;

endpackage

`default_nettype wire

/* hdl/line_line_closest_approach.sv */
// Closest approach between a wire and a track: one word accepted per cycle
// when not stalled.
// The depth is set by the two 48-stage restoring dividers for s and t.
// A stall on the output holds the whole pipeline; nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits.
// Uses llca_pkg for widths, types and constants.
`default_nettype none

module line_line_closest_approach (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // wire_top_x/y/z, wire_bot_x/y/z, trk_pos_x/y/z, trk_dir_x/y/z, 24 bits each
    input  wire logic [287:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // gap_x/y/z, near_wire_x/y/z, near_trk_x/y/z, 24 bits each
    output logic [215:0]      m_tdata,
    // parallel_flag, saturated_flag
    output logic [1:0]        m_tuser
);

    localparam int NSTG = 9 + llca_pkg::DSTG + 6;
    localparam int SA   = 9 + llca_pkg::DSTG;

    logic adv;
    logic [NSTG-1:0] vld_reg;

    // Magnitude of a dot product.
    function automatic logic [llca_pkg::MAGW-1:0] mag_dot(
        input logic signed [llca_pkg::DOTW-1:0] v);
        logic signed [llca_pkg::DOTW-1:0] n;
        n = v[llca_pkg::DOTW-1] ? -v : v;
        return n[llca_pkg::MAGW-1:0];
    endfunction

    // Clip to the coordinate range; the top bit flags a clip.
    function automatic logic [llca_pkg::CW:0] sat_coord(
        input logic signed [llca_pkg::GW-1:0] v);
        logic [llca_pkg::CW:0] r;
        if (v > llca_pkg::GW'(llca_pkg::COORD_MAX)) begin
            r = {1'b1, llca_pkg::COORD_MAX};
        end else if (v < llca_pkg::GW'(llca_pkg::COORD_MIN)) begin
            r = {1'b1, llca_pkg::COORD_MIN};
        end else begin
            r = {1'b0, v[llca_pkg::CW-1:0]};
        end
        return r;
    endfunction

    // Signed difference of two coordinates, one bit wider.
    function automatic logic [llca_pkg::DFW-1:0] DFW_sub(
        input logic [llca_pkg::CW-1:0] x, input logic [llca_pkg::CW-1:0] y);
        return llca_pkg::DFW'($signed(x)) - llca_pkg::DFW'($signed(y));
    endfunction

    // The whole pipeline moves together unless the output word is held.
    assign adv      = !vld_reg[NSTG-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NSTG-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    // Stage 1: unpack, form wire direction and offset from the bottom end.
    llca_pkg::geo_t g1_reg, g1_next;
    logic signed [llca_pkg::DFW-1:0] p1_reg [3], p1_next [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            g1_next.pos[i] = s_tdata[24*(6+i) +: 24];
            g1_next.bot[i] = s_tdata[24*(3+i) +: 24];
            g1_next.dir[i] = s_tdata[24*(9+i) +: 24];
            g1_next.wv[i]  = DFW_sub(s_tdata[24*i +: 24], s_tdata[24*(3+i) +: 24]);
            p1_next[i]     = $signed(DFW_sub(s_tdata[24*(6+i) +: 24],
                                             s_tdata[24*(3+i) +: 24]));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            g1_reg <= g1_next;
            for (int i = 0; i < 3; i++) p1_reg[i] <= p1_next[i];
        end
    end

    // Stage 2: the fifteen component products.
    llca_pkg::geo_t g2_reg;
    logic signed [llca_pkg::PRW-1:0] dd2_reg [3], dw2_reg [3], ww2_reg [3];
    logic signed [llca_pkg::PRW-1:0] pd2_reg [3], pw2_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            g2_reg <= g1_reg;
            for (int i = 0; i < 3; i++) begin
                dd2_reg[i] <= $signed(g1_reg.dir[i]) * $signed(g1_reg.dir[i]);
                dw2_reg[i] <= $signed(g1_reg.dir[i]) * $signed(g1_reg.wv[i]);
                ww2_reg[i] <= $signed(g1_reg.wv[i]) * $signed(g1_reg.wv[i]);
                pd2_reg[i] <= p1_reg[i] * $signed(g1_reg.dir[i]);
                pw2_reg[i] <= p1_reg[i] * $signed(g1_reg.wv[i]);
            end
        end
    end

    // Stage 3: dot products a = d.d, b = d.w, c = w.w, e = p.d, f = p.w.
    llca_pkg::geo_t g3_reg;
    logic signed [llca_pkg::DOTW-1:0] a3_reg, b3_reg, c3_reg, e3_reg, f3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            g3_reg <= g2_reg;
            a3_reg <= llca_pkg::DOTW'(dd2_reg[0]) + llca_pkg::DOTW'(dd2_reg[1])
                    + llca_pkg::DOTW'(dd2_reg[2]);
            b3_reg <= llca_pkg::DOTW'(dw2_reg[0]) + llca_pkg::DOTW'(dw2_reg[1])
                    + llca_pkg::DOTW'(dw2_reg[2]);
            c3_reg <= llca_pkg::DOTW'(ww2_reg[0]) + llca_pkg::DOTW'(ww2_reg[1])
                    + llca_pkg::DOTW'(ww2_reg[2]);
            e3_reg <= llca_pkg::DOTW'(pd2_reg[0]) + llca_pkg::DOTW'(pd2_reg[1])
                    + llca_pkg::DOTW'(pd2_reg[2]);
            f3_reg <= llca_pkg::DOTW'(pw2_reg[0]) + llca_pkg::DOTW'(pw2_reg[1])
                    + llca_pkg::DOTW'(pw2_reg[2]);
        end
    end

    // Stage 4: magnitudes and signs of the dot products.
    llca_pkg::geo_t g4_reg;
    logic [llca_pkg::MAGW-1:0] ma4_reg, mb4_reg, mc4_reg, me4_reg, mf4_reg;
    logic sb4_reg, se4_reg, sf4_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            g4_reg  <= g3_reg;
            ma4_reg <= mag_dot(a3_reg);
            mb4_reg <= mag_dot(b3_reg);
            mc4_reg <= mag_dot(c3_reg);
            me4_reg <= mag_dot(e3_reg);
            mf4_reg <= mag_dot(f3_reg);
            sb4_reg <= b3_reg[llca_pkg::DOTW-1];
            se4_reg <= e3_reg[llca_pkg::DOTW-1];
            sf4_reg <= f3_reg[llca_pkg::DOTW-1];
        end
    end

    // Stage 5: split products bb, ac, ec, bf, be, af into 25x25 partials.
    llca_pkg::geo_t g5_reg;
    logic [llca_pkg::MAGW-1:0] opx [6], opy [6];
    logic [5:0] sg5_next, sg5_reg;
    logic [llca_pkg::PRW-1:0] pp5_reg [6][4];

    always_comb begin
        opx[0] = mb4_reg; opy[0] = mb4_reg;
        opx[1] = ma4_reg; opy[1] = mc4_reg;
        opx[2] = me4_reg; opy[2] = mc4_reg;
        opx[3] = mb4_reg; opy[3] = mf4_reg;
        opx[4] = mb4_reg; opy[4] = me4_reg;
        opx[5] = ma4_reg; opy[5] = mf4_reg;
        sg5_next = {sf4_reg, sb4_reg ^ se4_reg, sb4_reg ^ sf4_reg, se4_reg, 1'b0, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            g5_reg  <= g4_reg;
            sg5_reg <= sg5_next;
            for (int k = 0; k < 6; k++) begin
                pp5_reg[k][0] <= opx[k][llca_pkg::HW-1:0] * opy[k][llca_pkg::HW-1:0];
                pp5_reg[k][1] <= opx[k][llca_pkg::HW-1:0]
                               * opy[k][llca_pkg::MAGW-1:llca_pkg::HW];
                pp5_reg[k][2] <= opx[k][llca_pkg::MAGW-1:llca_pkg::HW]
                               * opy[k][llca_pkg::HW-1:0];
                pp5_reg[k][3] <= opx[k][llca_pkg::MAGW-1:llca_pkg::HW]
                               * opy[k][llca_pkg::MAGW-1:llca_pkg::HW];
            end
        end
    end

    // Stage 6: recombine the partial products.
    llca_pkg::geo_t g6_reg;
    logic [5:0] sg6_reg;
    logic [llca_pkg::UPW-1:0] u6_reg [6];

    always_ff @(posedge aclk) begin
        if (adv) begin
            g6_reg  <= g5_reg;
            sg6_reg <= sg5_reg;
            for (int k = 0; k < 6; k++) begin
                u6_reg[k] <= (llca_pkg::UPW'(pp5_reg[k][3]) << (2 * llca_pkg::HW))
                           + (llca_pkg::UPW'(pp5_reg[k][1]) << llca_pkg::HW)
                           + (llca_pkg::UPW'(pp5_reg[k][2]) << llca_pkg::HW)
                           + llca_pkg::UPW'(pp5_reg[k][0]);
            end
        end
    end

    // Stage 7: signed products, determinant and the two numerators.
    llca_pkg::geo_t g7_reg;
    logic signed [llca_pkg::NW-1:0] sp7 [6];
    logic signed [llca_pkg::NW-1:0] det7_reg, ns7_reg, nt7_reg;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            sp7[k] = sg6_reg[k] ? -$signed({2'b00, u6_reg[k]}) : $signed({2'b00, u6_reg[k]});
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            g7_reg   <= g6_reg;
            det7_reg <= sp7[0] - sp7[1];
            ns7_reg  <= sp7[2] - sp7[3];
            nt7_reg  <= sp7[4] - sp7[5];
        end
    end

    // Stage 8: parallel check, magnitudes and quotient signs.
    llca_pkg::geo_t g8_reg;
    logic [llca_pkg::UPW-1:0] md8_reg, ms8_reg, mt8_reg;
    logic par8_reg, ngs8_reg, ngt8_reg;
    logic signed [llca_pkg::NW-1:0] md8_w, ms8_w, mt8_w;

    always_comb begin
        md8_w = det7_reg[llca_pkg::NW-1] ? -det7_reg : det7_reg;
        ms8_w = ns7_reg[llca_pkg::NW-1] ? -ns7_reg : ns7_reg;
        mt8_w = nt7_reg[llca_pkg::NW-1] ? -nt7_reg : nt7_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            g8_reg   <= g7_reg;
            md8_reg  <= md8_w[llca_pkg::UPW-1:0];
            ms8_reg  <= ms8_w[llca_pkg::UPW-1:0];
            mt8_reg  <= mt8_w[llca_pkg::UPW-1:0];
            par8_reg <= (det7_reg == '0);
            ngs8_reg <= ns7_reg[llca_pkg::NW-1] ^ det7_reg[llca_pkg::NW-1];
            ngt8_reg <= nt7_reg[llca_pkg::NW-1] ^ det7_reg[llca_pkg::NW-1];
        end
    end

    // Stage 9: scaled numerators with half the divisor added for rounding.
    llca_pkg::geo_t g9_reg;
    logic [llca_pkg::UPW-1:0] md9_reg;
    logic [llca_pkg::XW-1:0] xs9_reg, xt9_reg;
    logic par9_reg, ngs9_reg, ngt9_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            g9_reg   <= g8_reg;
            md9_reg  <= md8_reg;
            xs9_reg  <= (llca_pkg::XW'(ms8_reg) << llca_pkg::FRAC)
                      + llca_pkg::XW'(md8_reg >> 1);
            xt9_reg  <= (llca_pkg::XW'(mt8_reg) << llca_pkg::FRAC)
                      + llca_pkg::XW'(md8_reg >> 1);
            par9_reg <= par8_reg;
            ngs9_reg <= ngs8_reg;
            ngt9_reg <= ngt8_reg;
        end
    end

    // Divider: the first stage flags a quotient too large for the clamp,
    // then one restoring step per stage from the top quotient bit down.
    llca_pkg::geo_t               dg_reg  [llca_pkg::DSTG];
    llca_pkg::dctl_t              dc_reg  [llca_pkg::DSTG];
    logic [llca_pkg::UPW-1:0]     dmd_reg [llca_pkg::DSTG];
    logic [llca_pkg::XW-1:0]      drs_reg [llca_pkg::DSTG];
    logic [llca_pkg::XW-1:0]      drt_reg [llca_pkg::DSTG];
    logic [llca_pkg::QW-1:0]      dqs_reg [llca_pkg::DSTG];
    logic [llca_pkg::QW-1:0]      dqt_reg [llca_pkg::DSTG];

    for (genvar j = 0; j < llca_pkg::DSTG; j++) begin : g_div
        if (j == 0) begin : g_first
            logic [llca_pkg::XW-1:0] lim;
            assign lim = llca_pkg::XW'(md9_reg) << llca_pkg::QW;
            always_ff @(posedge aclk) begin
                if (adv) begin
                    dg_reg[0]        <= g9_reg;
                    dmd_reg[0]       <= md9_reg;
                    drs_reg[0]       <= xs9_reg;
                    drt_reg[0]       <= xt9_reg;
                    dqs_reg[0]       <= '0;
                    dqt_reg[0]       <= '0;
                    dc_reg[0].par    <= par9_reg;
                    dc_reg[0].neg_s  <= ngs9_reg;
                    dc_reg[0].neg_t  <= ngt9_reg;
                    dc_reg[0].ovf_s  <= (xs9_reg >= lim);
                    dc_reg[0].ovf_t  <= (xt9_reg >= lim);
                end
            end
        end else begin : g_step
            localparam int B = llca_pkg::DSTG - 1 - j;
            logic [llca_pkg::XW-1:0] sub;
            logic ge_s, ge_t;
            assign sub  = llca_pkg::XW'(dmd_reg[j-1]) << B;
            assign ge_s = (drs_reg[j-1] >= sub);
            assign ge_t = (drt_reg[j-1] >= sub);
            always_ff @(posedge aclk) begin
                if (adv) begin
                    dg_reg[j]  <= dg_reg[j-1];
                    dc_reg[j]  <= dc_reg[j-1];
                    dmd_reg[j] <= dmd_reg[j-1];
                    drs_reg[j] <= ge_s ? drs_reg[j-1] - sub : drs_reg[j-1];
                    drt_reg[j] <= ge_t ? drt_reg[j-1] - sub : drt_reg[j-1];
                    dqs_reg[j] <= dqs_reg[j-1] | (llca_pkg::QW'(ge_s) << B);
                    dqt_reg[j] <= dqt_reg[j-1] | (llca_pkg::QW'(ge_t) << B);
                end
            end
        end
    end

    // Stage A: clamp the parameters, zero them for parallel lines, and
    // take component magnitudes with the product signs.
    localparam int DL = llca_pkg::DSTG - 1;
    llca_pkg::geo_t ga_reg;
    logic [llca_pkg::QW-1:0] qsa_reg, qta_reg, qsa_next, qta_next;
    logic [llca_pkg::CW-1:0] mda_reg [3], mwa_reg [3];
    logic [2:0] ssa_reg, sta_reg;
    logic signed [llca_pkg::DFW-1:0] mda_w [3], mwa_w [3];
    logic para_reg;

    always_comb begin
        if (dc_reg[DL].par) begin
            qsa_next = '0;
            qta_next = '0;
        end else begin
            qsa_next = dc_reg[DL].ovf_s ? llca_pkg::PAR_LIMIT : dqs_reg[DL];
            qta_next = dc_reg[DL].ovf_t ? llca_pkg::PAR_LIMIT : dqt_reg[DL];
        end
        for (int i = 0; i < 3; i++) begin
            mda_w[i] = llca_pkg::DFW'($signed(dg_reg[DL].dir[i]));
            mda_w[i] = mda_w[i][llca_pkg::DFW-1] ? -mda_w[i] : mda_w[i];
            mwa_w[i] = $signed(dg_reg[DL].wv[i]);
            mwa_w[i] = mwa_w[i][llca_pkg::DFW-1] ? -mwa_w[i] : mwa_w[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ga_reg   <= dg_reg[DL];
            para_reg <= dc_reg[DL].par;
            qsa_reg  <= qsa_next;
            qta_reg  <= qta_next;
            for (int i = 0; i < 3; i++) begin
                mda_reg[i] <= mda_w[i][llca_pkg::CW-1:0];
                mwa_reg[i] <= mwa_w[i][llca_pkg::CW-1:0];
                ssa_reg[i] <= dc_reg[DL].neg_s ^ dg_reg[DL].dir[i][llca_pkg::CW-1];
                sta_reg[i] <= dc_reg[DL].neg_t ^ dg_reg[DL].wv[i][llca_pkg::DFW-1];
            end
        end
    end

    // Stage B: parameter times component as two partial products each.
    llca_pkg::geo_t gb_reg;
    logic [2:0] ssb_reg, stb_reg;
    logic parb_reg;
    logic [2*llca_pkg::CW-1:0] slo_reg [3], shi_reg [3], tlo_reg [3], thi_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            gb_reg   <= ga_reg;
            ssb_reg  <= ssa_reg;
            stb_reg  <= sta_reg;
            parb_reg <= para_reg;
            for (int i = 0; i < 3; i++) begin
                slo_reg[i] <= qsa_reg[llca_pkg::QLW-1:0] * mda_reg[i];
                shi_reg[i] <= llca_pkg::CW'(qsa_reg[llca_pkg::QW-1:llca_pkg::QLW]) * mda_reg[i];
                tlo_reg[i] <= qta_reg[llca_pkg::QLW-1:0] * mwa_reg[i];
                thi_reg[i] <= llca_pkg::CW'(qta_reg[llca_pkg::QW-1:llca_pkg::QLW]) * mwa_reg[i];
            end
        end
    end

    // Stage C: recombine, round off the fraction bits and apply the sign.
    llca_pkg::geo_t gc_reg;
    logic parc_reg;
    logic [llca_pkg::SPW-1:0] ms_w [3], mt_w [3];
    logic signed [llca_pkg::RW+1:0] rs_w [3], rt_w [3];
    logic signed [llca_pkg::RW+1:0] rsc_reg [3], rtc_reg [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ms_w[i] = (llca_pkg::SPW'(shi_reg[i]) << llca_pkg::QLW)
                    + llca_pkg::SPW'(slo_reg[i]) + (llca_pkg::SPW'(1) << (llca_pkg::FRAC - 1));
            mt_w[i] = (llca_pkg::SPW'(thi_reg[i]) << llca_pkg::QLW)
                    + llca_pkg::SPW'(tlo_reg[i]) + (llca_pkg::SPW'(1) << (llca_pkg::FRAC - 1));
            rs_w[i] = $signed({2'b00, ms_w[i][llca_pkg::SPW-1:llca_pkg::FRAC]});
            rt_w[i] = $signed({2'b00, mt_w[i][llca_pkg::SPW-1:llca_pkg::FRAC]});
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            gc_reg   <= gb_reg;
            parc_reg <= parb_reg;
            for (int i = 0; i < 3; i++) begin
                rsc_reg[i] <= ssb_reg[i] ? -rs_w[i] : rs_w[i];
                rtc_reg[i] <= stb_reg[i] ? -rt_w[i] : rt_w[i];
            end
        end
    end

    // Stage D: closest points on the track and on the wire.
    logic pard_reg;
    logic signed [llca_pkg::PTW-1:0] ntd_reg [3], nwd_reg [3];

    always_ff @(posedge aclk) begin
        if (adv) begin
            pard_reg <= parc_reg;
            for (int i = 0; i < 3; i++) begin
                ntd_reg[i] <= llca_pkg::PTW'($signed(gc_reg.pos[i]))
                            + llca_pkg::PTW'(rsc_reg[i]);
                nwd_reg[i] <= llca_pkg::PTW'($signed(gc_reg.bot[i]))
                            + llca_pkg::PTW'(rtc_reg[i]);
            end
        end
    end

    // Stage E: gap from the unclipped points; clip the points.
    logic pare_reg, clpe_reg;
    logic signed [llca_pkg::GW-1:0] gpe_reg [3];
    logic [llca_pkg::CW-1:0] nte_reg [3], nwe_reg [3];
    logic [llca_pkg::CW:0] snt_w [3], snw_w [3];
    logic clpe_next;

    always_comb begin
        clpe_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
            snt_w[i]  = sat_coord(llca_pkg::GW'(ntd_reg[i]));
            snw_w[i]  = sat_coord(llca_pkg::GW'(nwd_reg[i]));
            clpe_next = clpe_next | snt_w[i][llca_pkg::CW] | snw_w[i][llca_pkg::CW];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pare_reg <= pard_reg;
            clpe_reg <= clpe_next;
            for (int i = 0; i < 3; i++) begin
                gpe_reg[i] <= llca_pkg::GW'(ntd_reg[i]) - llca_pkg::GW'(nwd_reg[i]);
                nte_reg[i] <= snt_w[i][llca_pkg::CW-1:0];
                nwe_reg[i] <= snw_w[i][llca_pkg::CW-1:0];
            end
        end
    end

    // Stage F: clip the gap and load the output word.
    logic [llca_pkg::CW:0] sgp_w [3];
    logic clpf_next;
    logic [215:0] out_data_reg, out_data_next;
    logic [1:0] out_user_reg;

    always_comb begin
        clpf_next = clpe_reg;
        for (int i = 0; i < 3; i++) begin
            sgp_w[i]  = sat_coord(gpe_reg[i]);
            clpf_next = clpf_next | sgp_w[i][llca_pkg::CW];
            out_data_next[24*i +: 24]     = sgp_w[i][llca_pkg::CW-1:0];
            out_data_next[24*(3+i) +: 24] = nwe_reg[i];
            out_data_next[24*(6+i) +: 24] = nte_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= out_data_next;
            out_user_reg <= {clpf_next, pare_reg};
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_user_reg;

    // Without clipping, the x gap equals track point minus wire point.
    a_gap_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tdata[23:0] == 24'(m_tdata[167:144] - m_tdata[95:72]))
        else $error("gap does not match the closest points");

    // Parallel lines use zero parameters.
    a_par_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[SA] && para_reg |-> qsa_reg == '0 && qta_reg == '0)
        else $error("parameters not zero for parallel lines");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire
